// File: src/tpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpm_pkg: shared types and constants of the two-port terminal mux
// Word layouts, action and function codes, status constants, depth defaults.
// ----------------------------------------------------------------------------
package tpm_pkg;

    localparam int unsigned PORTS          = 2;
    localparam int unsigned RX_DEPTH_DEF   = 256;
    localparam int unsigned TX_DEPTH_DEF   = 32;

    // action codes of an input word
    localparam logic [2:0] ACT_FUNC   = 3'd0;
    localparam logic [2:0] ACT_IO     = 3'd1;
    localparam logic [2:0] ACT_RX     = 3'd2;
    localparam logic [2:0] ACT_TX     = 3'd3;
    localparam logic [2:0] ACT_LINK   = 3'd4;
    localparam logic [2:0] ACT_UNLINK = 3'd5;

    // function word outcome
    localparam logic [1:0] FR_DECLINED  = 2'd0;
    localparam logic [1:0] FR_ACCEPTED  = 2'd1;
    localparam logic [1:0] FR_PROCESSED = 2'd2;

    // function groups, bits 11..6
    localparam logic [5:0] GRP_LATCH_MAX = 6'o05;
    localparam logic [5:0] GRP_MCLEAR    = 6'o07;
    localparam logic [5:0] GRP_DESELECT  = 6'o60;
    localparam logic [5:0] GRP_CONNECT   = 6'o70;

    // latched operation, bits 8..6
    localparam logic [2:0] OP_STATUS = 3'o0;
    localparam logic [2:0] OP_READ   = 3'o1;
    localparam logic [2:0] OP_WRITE  = 3'o2;

    localparam logic [4:0]  ST_RESET    = 5'o26;
    localparam int unsigned ST_IRDY_BIT = 3;
    localparam logic [11:0] RD_MARK     = 12'o6000;

    typedef struct packed {
        logic [2:0]  action;
        logic [11:0] func_code;
        logic        chan_full;
        logic [11:0] chan_data;
        logic        line_port;
        logic [7:0]  line_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  func_result;
        logic        chan_full_out;
        logic [11:0] chan_data_out;
        logic        tx_valid;
        logic [6:0]  tx_byte;
        logic        rx_taken;
        logic        link_port;
        logic        link_ok;
    } t_out_word;

endpackage
`default_nettype wire

// File: src/tpm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpm_in_if: input word channel
// Valid/ready handshake carrying one input word.
// ----------------------------------------------------------------------------
interface tpm_in_if;
    logic              valid;
    logic              ready;
    tpm_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/tpm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpm_out_if: result word channel
// Valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface tpm_out_if;
    logic               valid;
    logic               ready;
    tpm_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/tpm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpm_ram: byte buffer memory
// One write port, one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module tpm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: src/two_port_terminal_mux.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_port_terminal_mux: two-port terminal multiplexer on a 12-bit channel
// Function decode, channel status/read/write, line receive/transmit/link.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  i_in     | in  | action, func_code, chan_full, chan_data, line_port, line_byte
//  o_out    | out | func_result, chan_full_out, chan_data_out, tx_valid, tx_byte,
//           |     | rx_taken, link_port, link_ok
//
//  Input register, one decode/update stage, result register; one word per
//  cycle sustained while the output does not stall. State updates and the
//  buffer memory access happen as a word leaves the input register; buffer
//  data is merged into the result at the output. Reset clears all control
//  state at once; buffer contents are not cleared. A stalled output holds
//  the pipeline and the input deasserts ready once both stages are full.
// ----------------------------------------------------------------------------
module two_port_terminal_mux #(
    parameter int unsigned RX_DEPTH = tpm_pkg::RX_DEPTH_DEF,
    parameter int unsigned TX_DEPTH = tpm_pkg::TX_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tpm_in_if.sink     i_in,
    tpm_out_if.source  o_out
);

    localparam int unsigned NP    = tpm_pkg::PORTS;
    localparam int unsigned RXI_W = $clog2(RX_DEPTH);
    localparam int unsigned RXC_W = $clog2(RX_DEPTH + 1);
    localparam int unsigned RXA_W = $clog2(NP * RX_DEPTH);
    localparam int unsigned TXI_W = $clog2(TX_DEPTH);
    localparam int unsigned TXC_W = $clog2(TX_DEPTH + 1);
    localparam int unsigned TXA_W = $clog2(NP * TX_DEPTH);

    // pipeline
    logic               r_v1, r_v2;
    tpm_pkg::t_in_word  r_in;
    tpm_pkg::t_out_word r_res, n_res;
    logic               r_rx_sel, n_rx_sel, r_tx_sel, n_tx_sel;
    logic               adv1, out_free;

    // mux state
    logic              r_sel_vld, n_sel_vld;
    logic              r_sel_port, n_sel_port;
    logic [11:0]       r_latched, n_latched;
    logic [NP-1:0]     r_linked, n_linked;
    logic [NP-1:0]     r_irdy, n_irdy;
    logic [RXC_W-1:0]  r_rx_fill [NP];
    logic [RXC_W-1:0]  n_rx_fill [NP];
    logic [RXI_W-1:0]  r_rx_take [NP];
    logic [RXI_W-1:0]  n_rx_take [NP];
    logic [TXC_W-1:0]  r_tx_fill [NP];
    logic [TXC_W-1:0]  n_tx_fill [NP];
    logic [TXI_W-1:0]  r_tx_take [NP];
    logic [TXI_W-1:0]  n_tx_take [NP];

    // buffer ports
    logic             rx_we, rx_re, tx_we, tx_re;
    logic [RXA_W-1:0] rx_waddr, rx_raddr;
    logic [TXA_W-1:0] tx_waddr, tx_raddr;
    logic [7:0]       rx_q;
    logic [6:0]       tx_q;

    assign out_free   = !r_v2 || o_out.ready;
    assign adv1       = r_v1 && out_free;
    assign i_in.ready = !r_v1 || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_v1 <= i_in.valid;
            end
            if (out_free) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (adv1) begin
            r_res    <= n_res;
            r_rx_sel <= n_rx_sel;
            r_tx_sel <= n_tx_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_vld  <= 1'b0;
            r_sel_port <= 1'b0;
            r_latched  <= '0;
            r_linked   <= '0;
            r_irdy     <= {NP{tpm_pkg::ST_RESET[tpm_pkg::ST_IRDY_BIT]}};
            for (int i = 0; i < NP; i++) begin
                r_rx_fill[i] <= '0;
                r_rx_take[i] <= '0;
                r_tx_fill[i] <= '0;
                r_tx_take[i] <= '0;
            end
        end else begin
            r_sel_vld  <= n_sel_vld;
            r_sel_port <= n_sel_port;
            r_latched  <= n_latched;
            r_linked   <= n_linked;
            r_irdy     <= n_irdy;
            r_rx_fill  <= n_rx_fill;
            r_rx_take  <= n_rx_take;
            r_tx_fill  <= n_tx_fill;
            r_tx_take  <= n_tx_take;
        end
    end

    always_comb begin
        logic       p;
        logic       lp;
        logic       rdy;
        logic [4:0] st;

        p  = r_sel_port;
        lp = r_in.line_port;
        rdy = 1'b0;
        st  = tpm_pkg::ST_RESET;

        n_res      = '0;
        n_rx_sel   = 1'b0;
        n_tx_sel   = 1'b0;
        n_sel_vld  = r_sel_vld;
        n_sel_port = r_sel_port;
        n_latched  = r_latched;
        n_linked   = r_linked;
        n_irdy     = r_irdy;
        n_rx_fill  = r_rx_fill;
        n_rx_take  = r_rx_take;
        n_tx_fill  = r_tx_fill;
        n_tx_take  = r_tx_take;

        rx_we    = 1'b0;
        rx_re    = 1'b0;
        tx_we    = 1'b0;
        tx_re    = 1'b0;
        rx_waddr = lp ? RXA_W'(RX_DEPTH) + RXA_W'(r_rx_fill[lp]) : RXA_W'(r_rx_fill[lp]);
        rx_raddr = p ? RXA_W'(RX_DEPTH) + RXA_W'(r_rx_take[p]) : RXA_W'(r_rx_take[p]);
        tx_waddr = p ? TXA_W'(TX_DEPTH) + TXA_W'(r_tx_fill[p]) : TXA_W'(r_tx_fill[p]);
        tx_raddr = lp ? TXA_W'(TX_DEPTH) + TXA_W'(r_tx_take[lp]) : TXA_W'(r_tx_take[lp]);

        if (adv1) begin
            unique case (r_in.action)
                tpm_pkg::ACT_FUNC: begin
                    if (r_in.func_code[11:6] <= tpm_pkg::GRP_LATCH_MAX) begin
                        n_latched         = r_in.func_code;
                        n_res.func_result = tpm_pkg::FR_ACCEPTED;
                    end else if (r_in.func_code[11:6] == tpm_pkg::GRP_MCLEAR) begin
                        n_res.func_result = tpm_pkg::FR_PROCESSED;
                    end else if (r_in.func_code[11:6] == tpm_pkg::GRP_DESELECT) begin
                        n_sel_vld         = 1'b0;
                        n_res.func_result = tpm_pkg::FR_PROCESSED;
                    end else if (r_in.func_code[11:6] == tpm_pkg::GRP_CONNECT) begin
                        n_sel_vld         = 1'b1;
                        n_sel_port        = ~r_in.func_code[0];
                        n_res.func_result = tpm_pkg::FR_PROCESSED;
                    end else begin
                        n_res.func_result = tpm_pkg::FR_DECLINED;
                    end
                end
                tpm_pkg::ACT_IO: begin
                    n_res.chan_full_out = r_in.chan_full;
                    n_res.chan_data_out = r_in.chan_data;
                    if (r_sel_vld) begin
                        unique case (r_latched[8:6])
                            tpm_pkg::OP_STATUS: begin
                                if (!r_in.chan_full) begin
                                    rdy = r_linked[p] &&
                                          (RXC_W'(r_rx_take[p]) < r_rx_fill[p]);
                                    n_irdy[p] = rdy;
                                    st[tpm_pkg::ST_IRDY_BIT] = rdy;
                                    n_res.chan_full_out = 1'b1;
                                    n_res.chan_data_out = {7'b0, st};
                                end
                            end
                            tpm_pkg::OP_READ: begin
                                if (!r_in.chan_full && r_irdy[p]) begin
                                    rx_re               = 1'b1;
                                    n_rx_sel            = 1'b1;
                                    n_res.chan_full_out = 1'b1;
                                    n_irdy[p]           = 1'b0;
                                    if (RXC_W'(r_rx_take[p]) + 1'b1 >= r_rx_fill[p]) begin
                                        n_rx_take[p] = '0;
                                        n_rx_fill[p] = '0;
                                    end else begin
                                        n_rx_take[p] = r_rx_take[p] + 1'b1;
                                    end
                                end
                            end
                            tpm_pkg::OP_WRITE: begin
                                if (r_in.chan_full) begin
                                    n_res.chan_full_out = 1'b0;
                                    if (r_linked[p] && r_tx_fill[p] < TXC_W'(TX_DEPTH)) begin
                                        tx_we        = 1'b1;
                                        n_tx_fill[p] = r_tx_fill[p] + 1'b1;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                tpm_pkg::ACT_RX: begin
                    if (r_linked[lp] && r_rx_fill[lp] < RXC_W'(RX_DEPTH)) begin
                        rx_we          = 1'b1;
                        n_rx_fill[lp]  = r_rx_fill[lp] + 1'b1;
                        n_res.rx_taken = 1'b1;
                    end
                end
                tpm_pkg::ACT_TX: begin
                    if (r_linked[lp] && (TXC_W'(r_tx_take[lp]) < r_tx_fill[lp])) begin
                        tx_re          = 1'b1;
                        n_tx_sel       = 1'b1;
                        n_res.tx_valid = 1'b1;
                        if (TXC_W'(r_tx_take[lp]) + 1'b1 >= r_tx_fill[lp]) begin
                            n_tx_take[lp] = '0;
                            n_tx_fill[lp] = '0;
                        end else begin
                            n_tx_take[lp] = r_tx_take[lp] + 1'b1;
                        end
                    end
                end
                tpm_pkg::ACT_LINK: begin
                    if (!r_linked[0]) begin
                        n_linked[0]     = 1'b1;
                        n_rx_fill[0]    = '0;
                        n_rx_take[0]    = '0;
                        n_tx_fill[0]    = '0;
                        n_tx_take[0]    = '0;
                        n_res.link_port = 1'b0;
                        n_res.link_ok   = 1'b1;
                    end else if (!r_linked[1]) begin
                        n_linked[1]     = 1'b1;
                        n_rx_fill[1]    = '0;
                        n_rx_take[1]    = '0;
                        n_tx_fill[1]    = '0;
                        n_tx_take[1]    = '0;
                        n_res.link_port = 1'b1;
                        n_res.link_ok   = 1'b1;
                    end
                end
                tpm_pkg::ACT_UNLINK: begin
                    n_linked[lp] = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    tpm_ram #(
        .WIDTH (8),
        .DEPTH (NP * RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (r_in.line_byte),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_q)
    );

    tpm_ram #(
        .WIDTH (7),
        .DEPTH (NP * TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (r_in.chan_data[6:0]),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_q)
    );

    assign o_out.valid = r_v2;

    always_comb begin
        o_out.data = r_res;
        if (r_rx_sel) begin
            o_out.data.chan_data_out = tpm_pkg::RD_MARK | {4'b0, rx_q};
        end
        if (r_tx_sel) begin
            o_out.data.tx_byte = tx_q;
        end
    end

    // checks
    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv1 |=> r_v2)
        else $error("word lost between decode and result stage");

    for (genvar g = 0; g < NP; g++) begin : g_chk
        a_rx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_rx_fill[g] <= RXC_W'(RX_DEPTH)) &&
            ((RXC_W'(r_rx_take[g]) < r_rx_fill[g]) ||
             (r_rx_take[g] == '0 && r_rx_fill[g] == '0)))
            else $error("receive indices out of order");
        a_tx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_tx_fill[g] <= TXC_W'(TX_DEPTH)) &&
            ((TXC_W'(r_tx_take[g]) < r_tx_fill[g]) ||
             (r_tx_take[g] == '0 && r_tx_fill[g] == '0)))
            else $error("transmit indices out of order");
    end

endmodule
`default_nettype wire
